FILE: design/rag_pkg.sv
// ----------------------------------------------------------------------------
// rag_pkg
// Shared types, codes and widths of the rational ALU with GCD reduction.
// ----------------------------------------------------------------------------
package rag_pkg;

    // operand bits actually read from each 32-bit input field
    localparam int OPW = 32;
    // product width and width of a sum of two products
    localparam int PW  = 2 * OPW;
    localparam int MW  = PW + 1;
    localparam int KW  = $clog2(MW);
    localparam int CW  = $clog2(MW);
    localparam logic [63:0] NUM_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]   cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result_num;
        logic [62:0]        result_den;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_FORM,
        OP_GCD,
        OP_DIV_NUM,
        OP_DIV_DEN,
        OP_DIV_STEP,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_FORM,
        S_GCD,
        S_DIVN0,
        S_DIVN,
        S_DIVD0,
        S_DIVD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic skip;
        logic gcd_done;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

FILE: design/rational_alu_gcd_reduce.sv
// ----------------------------------------------------------------------------
// rational_alu_gcd_reduce
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_data (t_in)
//  output  | o_valid | i_stall | o_data (t_out)
//
//  One transaction at a time: 1 load, 3 multiplies on one shared 32x32
//  multiplier, a forming step, a binary GCD loop, then two restoring
//  divisions; errors and zero results skip the GCD and divisions.
//  A finished result sits in the output register while the next input is
//  taken. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_alu_gcd_reduce import rag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_ctl ctl;
    t_sts sts;

    rag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    rag_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_data  (i_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

FILE: design/rag_datapath.sv
// ----------------------------------------------------------------------------
// rag_datapath
// Operand registers, shared multiplier, binary GCD unit, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module rag_datapath import rag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    input  t_in  i_data,
    input  logic i_stall,
    output logic o_valid,
    output t_out o_data
);

    logic [1:0]     r_cmd;
    logic [OPW-1:0] r_an, r_ad, r_bn, r_bd;
    logic           r_san, r_sad, r_sbn, r_sbd;
    t_status        r_status;
    logic [PW-1:0]  r_p0, r_p1, r_p2;
    logic [MW-1:0]  r_nm;
    logic           r_neg;
    logic [MW-1:0]  r_x, r_y, r_g, r_q, r_qn;
    logic [KW-1:0]  r_k;
    logic [MW:0]    r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_ov;
    t_out           r_out;

    logic [OPW-1:0] an_v, ad_v, bn_v, bd_v;
    logic [OPW-1:0] an_m, ad_m, bn_m, bd_m;
    logic [OPW-1:0] ma, mb;
    logic [PW-1:0]  prod;
    logic           s0, s1, s2, sn;
    logic [MW-1:0]  p0x, p1x, f_num;
    logic [MW-1:0]  g_x, g_y;
    logic           g_inc;
    logic [MW:0]    d_t;
    logic           d_ge;
    logic [64:0]    nm65;
    logic [63:0]    nm_c;
    t_out           res;

    assign an_v = i_data.a_num[OPW-1:0];
    assign ad_v = i_data.a_den[OPW-1:0];
    assign bn_v = i_data.b_num[OPW-1:0];
    assign bd_v = i_data.b_den[OPW-1:0];
    assign an_m = an_v[OPW-1] ? (~an_v + 1'b1) : an_v;
    assign ad_m = ad_v[OPW-1] ? (~ad_v + 1'b1) : ad_v;
    assign bn_m = bn_v[OPW-1] ? (~bn_v + 1'b1) : bn_v;
    assign bd_m = bd_v[OPW-1] ? (~bd_v + 1'b1) : bd_v;

    // one shared multiplier, operands picked per product
    always_comb begin
        ma = r_ad;
        mb = r_bd;
        case (i_ctl.op)
            OP_MUL0: begin
                ma = r_an;
                mb = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            OP_MUL1: begin
                ma = r_bn;
                mb = r_ad;
            end
            default: begin
                ma = r_ad;
                mb = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
        endcase
    end
    assign prod = PW'(ma) * PW'(mb);

    // signs of the three products and the combined numerator
    always_comb begin
        s0  = r_san ^ ((r_cmd == CMD_MUL) ? r_sbn : r_sbd);
        s1  = r_sbn ^ r_sad ^ (r_cmd == CMD_SUB);
        s2  = r_sad ^ ((r_cmd == CMD_DIV) ? r_sbn : r_sbd);
        p0x = MW'(r_p0);
        p1x = MW'(r_p1);
        sn  = s0;
        f_num = p0x;
        if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
            if (s0 == s1) begin
                f_num = p0x + p1x;
            end else if (p0x >= p1x) begin
                f_num = p0x - p1x;
            end else begin
                f_num = p1x - p0x;
                sn    = s1;
            end
        end
    end

    // one binary GCD step
    always_comb begin
        g_x   = r_x;
        g_y   = r_y;
        g_inc = 1'b0;
        if (!r_x[0] && !r_y[0]) begin
            g_x   = r_x >> 1;
            g_y   = r_y >> 1;
            g_inc = 1'b1;
        end else if (!r_x[0]) begin
            g_x = r_x >> 1;
        end else if (!r_y[0]) begin
            g_y = r_y >> 1;
        end else if (r_x >= r_y) begin
            g_x = (r_x - r_y) >> 1;
        end else begin
            g_y = (r_y - r_x) >> 1;
        end
    end

    // one restoring division step
    assign d_t  = {r_rem[MW-1:0], r_q[MW-1]};
    assign d_ge = d_t >= {1'b0, r_g};

    // final formatting of the result
    always_comb begin
        nm65 = 65'(r_qn);
        nm_c = (nm65 > 65'(NUM_MAG_MAX)) ? NUM_MAG_MAX : nm65[63:0];
        res.result_num = r_neg ? -$signed(nm_c) : $signed(nm_c);
        res.result_den = 63'(r_q);
        res.status     = ST_OK;
        if (r_status != ST_OK) begin
            res.result_num = '0;
            res.result_den = '0;
            res.status     = r_status;
        end else if (r_nm == '0) begin
            res.result_num = '0;
            res.result_den = 63'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                r_cmd <= i_data.cmd;
                r_an  <= an_m;
                r_ad  <= ad_m;
                r_bn  <= bn_m;
                r_bd  <= bd_m;
                r_san <= an_v[OPW-1];
                r_sad <= ad_v[OPW-1];
                r_sbn <= bn_v[OPW-1];
                r_sbd <= bd_v[OPW-1];
                if (ad_m == '0 || bd_m == '0) begin
                    r_status <= ST_ZDEN;
                end else if (i_data.cmd == CMD_DIV && bn_m == '0) begin
                    r_status <= ST_DIVZ;
                end else begin
                    r_status <= ST_OK;
                end
            end
            OP_MUL0: r_p0 <= prod;
            OP_MUL1: r_p1 <= prod;
            OP_MUL2: r_p2 <= prod;
            OP_FORM: begin
                r_nm  <= f_num;
                r_neg <= sn ^ s2;
                r_x   <= f_num;
                r_y   <= MW'(r_p2);
                r_k   <= '0;
            end
            OP_GCD: begin
                r_x <= g_x;
                r_y <= g_y;
                if (g_inc) begin
                    r_k <= r_k + 1'b1;
                end
            end
            OP_DIV_NUM: begin
                r_g   <= r_y << r_k;
                r_q   <= r_nm;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_DEN: begin
                r_qn  <= r_q;
                r_q   <= MW'(r_p2);
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= d_ge ? (d_t - {1'b0, r_g}) : d_t;
                r_q   <= {r_q[MW-2:0], d_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_EMIT: r_out <= res;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.op == OP_EMIT) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.skip     = (r_status != ST_OK) || (r_nm == '0);
    assign o_sts.gcd_done = (r_x == '0);
    assign o_sts.div_last = (r_cnt == CW'(MW - 1));
    assign o_sts.out_free = !r_ov || !i_stall;
    assign o_valid        = r_ov;
    assign o_data         = r_out;

endmodule

FILE: design/rag_ctrl.sv
// ----------------------------------------------------------------------------
// rag_ctrl
// Sequencer: products, numerator forming, GCD loop, two divisions, emit.
// ----------------------------------------------------------------------------
module rag_ctrl import rag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_FORM;
            S_FORM:  n_state = S_GCD;
            S_GCD: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else if (i_sts.gcd_done) begin
                    n_state = S_DIVN0;
                end
            end
            S_DIVN0: n_state = S_DIVN;
            S_DIVN:  if (i_sts.div_last) n_state = S_DIVD0;
            S_DIVD0: n_state = S_DIVD;
            S_DIVD:  if (i_sts.div_last) n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = (r_state != S_IDLE);
        o_ctl.op  = OP_NONE;
        unique case (r_state)
            S_IDLE:  if (i_valid) o_ctl.op = OP_LOAD;
            S_MUL0:  o_ctl.op = OP_MUL0;
            S_MUL1:  o_ctl.op = OP_MUL1;
            S_MUL2:  o_ctl.op = OP_MUL2;
            S_FORM:  o_ctl.op = OP_FORM;
            S_GCD:   if (!i_sts.skip && !i_sts.gcd_done) o_ctl.op = OP_GCD;
            S_DIVN0: o_ctl.op = OP_DIV_NUM;
            S_DIVN:  o_ctl.op = OP_DIV_STEP;
            S_DIVD0: o_ctl.op = OP_DIV_DEN;
            S_DIVD:  o_ctl.op = OP_DIV_STEP;
            S_DONE:  if (i_sts.out_free) o_ctl.op = OP_EMIT;
            default: o_ctl.op = OP_NONE;
        endcase
    end

endmodule

FILE: test/tb_rational_alu_gcd_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_alu_gcd_reduce
// Drives directed and random fraction pairs through the rational ALU under
// several idle and stall mixes, predicts or takes each expected result and compares it.
// ----------------------------------------------------------------------------
module tb_rational_alu_gcd_reduce;
    import rag_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM = 1500;
    localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    int   mismatches = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    t_out fraction_q[$];

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;
    t_row rows[$];

    rational_alu_gcd_reduce dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] mag_of(logic signed [31:0] v, output bit neg);
        neg = v[31];
        return neg ? 64'(-65'(v)) : 64'(v);
    endfunction

    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // sign plus magnitude, mirrors the exact arithmetic of the block
    function automatic t_out reduce_fraction(t_in d);
        t_out r;
        bit an_s, ad_s, bn_s, bd_s, n_s, d_s, t_s, u_s;
        logic [63:0] an, ad, bn, bd, nm, dm, tm, um, g;
        an = mag_of(d.a_num, an_s);
        ad = mag_of(d.a_den, ad_s);
        bn = mag_of(d.b_num, bn_s);
        bd = mag_of(d.b_den, bd_s);
        r = '0;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZDEN;
            return r;
        end
        if (d.cmd == CMD_DIV && bn == 0) begin
            r.status = ST_DIVZ;
            return r;
        end
        d_s = ad_s ^ bd_s;
        dm = ad * bd;
        case (d.cmd)
            CMD_ADD, CMD_SUB: begin
                t_s = an_s ^ bd_s;
                tm = an * bd;
                u_s = bn_s ^ ad_s ^ (d.cmd == CMD_SUB);
                um = bn * ad;
                if (t_s == u_s) begin
                    n_s = t_s;
                    nm = tm + um;
                end else if (tm >= um) begin
                    n_s = t_s;
                    nm = tm - um;
                end else begin
                    n_s = u_s;
                    nm = um - tm;
                end
            end
            CMD_MUL: begin
                n_s = an_s ^ bn_s;
                nm = an * bn;
            end
            default: begin
                n_s = an_s ^ bd_s;
                nm = an * bd;
                d_s = ad_s ^ bn_s;
                dm = ad * bn;
            end
        endcase
        if (nm == 0) begin
            r.result_den = 63'd1;
            return r;
        end
        g = euclid(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (nm > NUM_MAG_MAX) nm = NUM_MAG_MAX;
        r.result_num = (n_s ^ d_s) ? -nm : nm;
        r.result_den = dm[62:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH t=%0t %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic t_in mk(t_cmd c, logic signed [31:0] an, logic signed [31:0] ad,
                               logic signed [31:0] bn, logic signed [31:0] bd);
        t_in d;
        d.cmd = c;
        d.a_num = an;
        d.a_den = ad;
        d.b_num = bn;
        d.b_den = bd;
        return d;
    endfunction

    function automatic t_out res(logic signed [63:0] n, logic [62:0] dd, t_status s);
        t_out r;
        r.result_num = n;
        r.result_den = dd;
        r.status = s;
        return r;
    endfunction

    task automatic add_row(t_in d, bit typed, t_out want);
        t_row r;
        r.item = d;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MAXP;
            1: return MINN;
            2: return 32'sd0;
            3, 4: return $signed(32'($urandom_range(0, 40)) - 32'd20);
            5, 6: return $signed(32'($urandom_range(0, 2000)) - 32'd1000);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in d;
        d.cmd = 2'($urandom_range(0, 3));
        d.a_num = rand_operand();
        d.a_den = rand_operand();
        d.b_num = rand_operand();
        d.b_den = rand_operand();
        // keep zero denominators occasional so most transactions do real work
        if (d.a_den == 0 && $urandom_range(0, 3) != 0) d.a_den = 32'sd7;
        if (d.b_den == 0 && $urandom_range(0, 3) != 0) d.b_den = -32'sd3;
        return d;
    endfunction

    // hold valid across back-to-back transactions, drop it only while idling
    task automatic send(t_in d, bit typed, t_out want);
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        fraction_q.push_back(typed ? want : reduce_fraction(d));
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver side: stall randomly, check each accepted result
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (fraction_q.size() == 0) begin
                    report_mismatch("unexpected result", o_data.result_num, 0);
                end else begin
                    want = fraction_q.pop_front();
                    if (o_data.result_num !== want.result_num)
                        report_mismatch("result_num", o_data.result_num, want.result_num);
                    if (o_data.result_den !== want.result_den)
                        report_mismatch("result_den", 64'(o_data.result_den),
                                        64'(want.result_den));
                    if (o_data.status !== want.status)
                        report_mismatch("status", 64'(o_data.status), 64'(want.status));
                end
            end
            i_stall <= (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int wait_n;
        add_row(mk(CMD_ADD, 1, 0, 1, 1), 1'b1, res(0, 0, ST_ZDEN));
        add_row(mk(CMD_DIV, 1, 1, 5, 0), 1'b1, res(0, 0, ST_ZDEN));
        add_row(mk(CMD_DIV, 3, 4, 0, 7), 1'b1, res(0, 0, ST_DIVZ));
        add_row(mk(CMD_DIV, 3, 0, 0, 7), 1'b1, res(0, 0, ST_ZDEN));
        add_row(mk(CMD_MUL, 0, 5, 9, 4), 1'b1, res(0, 1, ST_OK));
        add_row(mk(CMD_SUB, 3, 4, 3, 4), 1'b1, res(0, 1, ST_OK));
        add_row(mk(CMD_ADD, 1, 2, 1, 3), 1'b1, res(5, 6, ST_OK));
        add_row(mk(CMD_SUB, 1, 2, 1, 3), 1'b1, res(1, 6, ST_OK));
        add_row(mk(CMD_MUL, 2, 3, 3, 4), 1'b1, res(1, 2, ST_OK));
        add_row(mk(CMD_DIV, 2, 3, 4, 9), 1'b1, res(3, 2, ST_OK));
        add_row(mk(CMD_MUL, -1, 2, 1, -3), 1'b1, res(1, 6, ST_OK));
        add_row(mk(CMD_MUL, 1, -2, 1, 3), 1'b1, res(-1, 6, ST_OK));
        add_row(mk(CMD_MUL, MINN, 1, MINN, 1), 1'b0, '0);
        add_row(mk(CMD_MUL, MINN, MINN, MAXP, MAXP), 1'b0, '0);
        add_row(mk(CMD_ADD, MAXP, 1, MAXP, 1), 1'b0, '0);
        add_row(mk(CMD_SUB, MINN, 1, MAXP, 1), 1'b0, '0);
        add_row(mk(CMD_ADD, MAXP, MINN, MINN, MAXP), 1'b0, '0);
        add_row(mk(CMD_DIV, MINN, MAXP, MAXP, MINN), 1'b0, '0);
        add_row(mk(CMD_DIV, 1, MAXP, MINN, 1), 1'b0, '0);
        add_row(mk(CMD_SUB, -32'sd1, -32'sd1, 32'sd1, MINN), 1'b0, '0);
        add_row(mk(CMD_ADD, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                   32'sh5555_5555), 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send(rows[k].item, rows[k].typed, rows[k].want);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int k = 0; k < N_RANDOM / 4; k++) send(rand_item(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        wait_n = 0;
        while (fraction_q.size() != 0) @(posedge i_clk);
        while (wait_n < 400) begin
            @(posedge i_clk);
            wait_n++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: rational_alu_gcd_reduce.f
design/rag_pkg.sv
design/rag_datapath.sv
design/rag_ctrl.sv
design/rational_alu_gcd_reduce.sv
test/tb_rational_alu_gcd_reduce.sv
